FILE: rtl/rfs_pkg.sv
// ----------------------------------------------------------------------------
// rfs_pkg
// shared types, constants and the prefix classifier of the frame splitter
// ----------------------------------------------------------------------------
package rfs_pkg;

  localparam int BUF_DEPTH   = 64;
  localparam int ADDR_W      = $clog2(BUF_DEPTH);
  localparam int FILL_W      = $clog2(BUF_DEPTH + 1);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CR_BYTE = 8'h0D;
  localparam int         TX_BIT  = 7;
  localparam logic [7:0] CH_A    = 8'h41;
  localparam logic [7:0] CH_B    = 8'h42;
  localparam logic [7:0] CH_C    = 8'h43;
  localparam logic [7:0] CH_G    = 8'h47;
  localparam logic [7:0] CH_H    = 8'h48;
  localparam logic [7:0] CH_I    = 8'h49;
  localparam logic [7:0] CH_J    = 8'h4A;
  localparam logic [7:0] CH_K    = 8'h4B;
  localparam logic [7:0] CH_L    = 8'h4C;
  localparam logic [7:0] CH_M    = 8'h4D;
  localparam logic [7:0] CH_N    = 8'h4E;
  localparam logic [7:0] CH_P    = 8'h50;
  localparam logic [7:0] CH_S    = 8'h53;
  localparam logic [7:0] CH_T    = 8'h54;
  localparam logic [7:0] CH_U    = 8'h55;
  localparam logic [7:0] CH_V    = 8'h56;
  localparam logic [7:0] CH_W    = 8'h57;
  localparam logic [7:0] CH_X    = 8'h58;
  localparam logic [7:0] CH_Z    = 8'h5A;
  localparam logic [7:0] CH_AT   = 8'h40;
  localparam logic [7:0] CH_ONE  = 8'h31;

  typedef enum logic [2:0] {
    KIND_UNKNOWN,
    KIND_FIXED,
    KIND_TO_CR,
    KIND_S,
    KIND_C
  } kind_t;

  typedef struct packed {
    logic [7:0] data;
    logic       is_cr;
    kind_t      kind;
    logic [2:0] flen;
  } item_t;

  typedef struct packed {
    logic [FILL_W-1:0] fill;
    logic              pop;
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HEAD,
    ST_PFX,
    ST_S1,
    ST_C1,
    ST_C2,
    ST_FIX,
    ST_CHKCR,
    ST_TOCR,
    ST_TOCRD,
    ST_EMIT_RD,
    ST_EMIT_WR
  } state_t;

  function automatic item_t classify(input logic [7:0] b);
    item_t it;
    it.data  = b;
    it.is_cr = (b == CR_BYTE);
    it.flen  = 3'd0;
    unique case (b) inside
      CH_A, CH_B: begin
        it.kind = KIND_FIXED;
        it.flen = 3'd4;
      end
      CH_M, CH_P: begin
        it.kind = KIND_FIXED;
        it.flen = 3'd2;
      end
      CH_W, CH_G, CH_J, CH_N, CH_H, CH_I, CH_U: begin
        it.kind = KIND_FIXED;
        it.flen = 3'd1;
      end
      CH_K, CH_L: begin
        it.kind = KIND_FIXED;
        it.flen = 3'd3;
      end
      CH_V, CH_AT, CH_X, CH_Z: it.kind = KIND_TO_CR;
      CH_S:                    it.kind = KIND_S;
      CH_C:                    it.kind = KIND_C;
      default:                 it.kind = KIND_UNKNOWN;
    endcase
    return it;
  endfunction

  // circular buffer address of ptr + o, with o at most BUF_DEPTH
  function automatic logic [ADDR_W-1:0] ptr_add(input logic [ADDR_W-1:0] ptr,
                                                input logic [FILL_W-1:0] o);
    logic [FILL_W:0] s;
    s = (FILL_W+1)'(ptr) + (FILL_W+1)'(o);
    if (s >= (FILL_W+1)'(BUF_DEPTH)) begin
      s = s - (FILL_W+1)'(BUF_DEPTH);
    end
    return s[ADDR_W-1:0];
  endfunction

endpackage

FILE: rtl/rfs_front.sv
// ----------------------------------------------------------------------------
// rfs_front
// input side: tags each received byte with its prefix class and queues it
// ----------------------------------------------------------------------------
module rfs_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [7:0]    s_tdata,   // [7:0] rx_byte
  output logic          q_valid,
  input  logic          q_ready,
  output rfs_pkg::item_t q_item
);
  import rfs_pkg::*;

  item_t             q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pull;

  function automatic logic [QPTR_W-1:0] qinc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign s_tready = (count != QCNT_W'(QUEUE_DEPTH));
  assign q_valid  = (count != '0);
  assign q_item   = q[rd_ptr];
  assign push     = s_tvalid && s_tready;
  assign pull     = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= qinc(wr_ptr);
      end
      if (pull) begin
        rd_ptr <= qinc(rd_ptr);
      end
      if (push && !pull) begin
        count <= count + 1'b1;
      end else if (pull && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= classify(s_tdata);
    end
  end

endmodule

FILE: rtl/rfs_scan.sv
// ----------------------------------------------------------------------------
// rfs_scan
// back side: byte buffer, frame scanner and output register
// ----------------------------------------------------------------------------
module rfs_scan (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  output logic             q_ready,
  input  rfs_pkg::item_t   q_item,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [7:0]       m_tdata,
  output logic             m_tlast,
  output rfs_pkg::status_t status
);
  import rfs_pkg::*;

  item_t             mem [BUF_DEPTH];
  item_t             rdata;
  state_t            state;
  state_t            state_next;
  logic [ADDR_W-1:0] head;
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] off;
  logic [FILL_W-1:0] endp;
  logic [2:0]        flen;
  logic              c_one;
  logic [ADDR_W-1:0] raddr;
  logic [ADDR_W-1:0] tail;
  logic [2:0]        c_len;
  logic [2:0]        want_len;
  logic              fix_ok;
  logic              last;
  logic              out_free;
  logic              pop;
  logic              load;

  assign tail     = ptr_add(head, fill);
  assign raddr    = ptr_add(head, off);
  assign out_free = !m_tvalid || m_tready;
  assign last     = ((off + 1'b1) == endp);

  // length of a C frame from its second and third byte
  always_comb begin
    if (c_one && rdata.data == CH_T) begin
      c_len = 3'd4;
    end else if (c_one && rdata.data == CH_X) begin
      c_len = 3'd5;
    end else begin
      c_len = 3'd3;
    end
  end

  always_comb begin
    unique case (state)
      ST_S1:   want_len = 3'd2;
      ST_C2:   want_len = c_len;
      default: want_len = rdata.flen;
    endcase
  end

  assign fix_ok = (fill >= FILL_W'(want_len) + FILL_W'(2));

  // outputs
  always_comb begin
    pop  = (state == ST_IDLE) && q_valid;
    load = (state == ST_EMIT_WR) && out_free;
  end

  assign q_ready     = pop;
  assign status.fill = fill;
  assign status.pop  = pop;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (q_valid) state_next = ST_HEAD;
      ST_HEAD:    state_next = (fill == '0) ? ST_IDLE : ST_PFX;
      ST_PFX: begin
        unique case (rdata.kind)
          KIND_FIXED: state_next = fix_ok ? ST_FIX : ST_IDLE;
          KIND_TO_CR: state_next = ST_TOCR;
          KIND_S:     state_next = (fill < FILL_W'(2)) ? ST_IDLE : ST_S1;
          KIND_C:     state_next = (fill < FILL_W'(3)) ? ST_IDLE : ST_C1;
          default:    state_next = ST_HEAD;
        endcase
      end
      ST_S1: begin
        if (rdata.data[TX_BIT]) begin
          state_next = fix_ok ? ST_FIX : ST_IDLE;
        end else begin
          state_next = ST_TOCR;
        end
      end
      ST_C1:      state_next = ST_C2;
      ST_C2:      state_next = fix_ok ? ST_FIX : ST_IDLE;
      ST_FIX:     state_next = ST_CHKCR;
      ST_CHKCR:   state_next = rdata.is_cr ? ST_EMIT_RD : ST_HEAD;
      ST_TOCR:    state_next = (off >= fill) ? ST_IDLE : ST_TOCRD;
      ST_TOCRD:   state_next = rdata.is_cr ? ST_EMIT_RD : ST_TOCR;
      ST_EMIT_RD: state_next = ST_EMIT_WR;
      ST_EMIT_WR: begin
        if (load) begin
          state_next = last ? ST_HEAD : ST_EMIT_RD;
        end
      end
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      head     <= '0;
      fill     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        m_tvalid <= 1'b1;
        m_tdata  <= rdata.data;
        m_tlast  <= last;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          off <= '0;
          if (pop) begin
            if (fill == FILL_W'(BUF_DEPTH)) begin
              head <= ptr_add(head, FILL_W'(1));
            end else begin
              fill <= fill + 1'b1;
            end
          end
        end
        ST_HEAD: off <= FILL_W'(1);
        ST_PFX: begin
          unique case (rdata.kind)
            KIND_FIXED: begin
              flen <= rdata.flen;
              off  <= FILL_W'(rdata.flen) + FILL_W'(1);
            end
            KIND_TO_CR: off <= FILL_W'(1);
            KIND_S:     off <= FILL_W'(1);
            KIND_C:     off <= FILL_W'(2);
            default: begin
              head <= ptr_add(head, FILL_W'(1));
              fill <= fill - 1'b1;
              off  <= '0;
            end
          endcase
        end
        ST_S1: begin
          if (rdata.data[TX_BIT]) begin
            flen <= 3'd2;
            off  <= FILL_W'(3);
          end else begin
            off <= FILL_W'(1);
          end
        end
        ST_C1: c_one <= (rdata.data == CH_ONE);
        ST_C2: begin
          flen <= c_len;
          off  <= FILL_W'(c_len) + FILL_W'(1);
        end
        ST_CHKCR: begin
          off <= '0;
          if (rdata.is_cr) begin
            endp <= FILL_W'(flen) + FILL_W'(1);
          end else begin
            head <= ptr_add(head, FILL_W'(1));
            fill <= fill - 1'b1;
          end
        end
        ST_TOCRD: begin
          if (rdata.is_cr) begin
            endp <= off;
            off  <= '0;
          end else begin
            off <= off + 1'b1;
          end
        end
        ST_EMIT_WR: begin
          if (load) begin
            if (last) begin
              head <= ptr_add(head, endp + 1'b1);
              fill <= fill - (endp + 1'b1);
              off  <= '0;
            end else begin
              off <= off + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // byte buffer
  always_ff @(posedge clk) begin
    if (pop) begin
      mem[tail] <= q_item;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/response_frame_splitter_top.sv
// ----------------------------------------------------------------------------
// response_frame_splitter_top
// splits a received byte stream into response frames
// ----------------------------------------------------------------------------
// request in (s_*): one received byte per request. a four-entry queue takes
//   bytes while the scanner is busy; s_tready drops only when it is full.
// request out (m_*): frame bytes, prefix first, cr stripped, m_tlast on the
//   final byte of each frame. one registered output stage.
// each byte is appended to a circular buffer of BUF_DEPTH entries (oldest byte
//   dropped when full), then the scanner walks from the buffer head:
//   - append the byte and read the head prefix
//   - check the prefix, or search for the cr one byte at a time
//   - emit the frame bytes while m_tready is high
// the scanner reads the buffer through its single read port.
// reset empties the queue and the buffer and clears m_tvalid. a stalled
// receiver holds the scanner in its emit step; the queue accepts until full.
// ----------------------------------------------------------------------------
module response_frame_splitter_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] rx_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] frame_byte
  output logic       m_tlast
);
  import rfs_pkg::*;

  logic    q_valid;
  logic    q_ready;
  item_t   q_item;
  status_t status;

  rfs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  rfs_scan u_scan (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .status   (status)
  );

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    status.fill <= FILL_W'(BUF_DEPTH))
    else $error("buffer fill beyond depth");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (status.fill == '0) && !m_tvalid)
    else $error("reset left buffer or output busy");

  a_append: assert property (@(posedge clk) disable iff (rst)
    status.pop |=> (status.fill == $past(status.fill) + 1'b1) ||
                   ($past(status.fill) == FILL_W'(BUF_DEPTH)))
    else $error("append did not grow the buffer");

endmodule

FILE: dv/response_frame_splitter_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// response_frame_splitter_top_tb
// byte stream in, response frames out, checked against a software predictor
// ----------------------------------------------------------------------------
// every received byte accepted on the input stream is run through a model of
// the prefix scanner, which queues the frame bytes it should release. each
// output request is compared with the oldest queued byte. the stimulus is a
// directed set of frames per prefix and corner case, then mostly well-formed
// random frames mixed with noise, slipped and cut frames and overlong text.
// the sender runs in bursts, the receiver stalls in changing patterns and
// once holds off long enough to back the block up into its input.
// ----------------------------------------------------------------------------
module response_frame_splitter_top_tb;
  import rfs_pkg::*;

  class frame_scoreboard;
    localparam int MAX_BEATS = 64;

    typedef enum {HEAD_FIXED, HEAD_TO_CR, HEAD_DROP, HEAD_WAIT} head_rule_t;

    typedef struct {
      logic [7:0] data;
      logic       last;
    } beat_t;

    logic [7:0] rx_hist[$];
    beat_t      frame_beats[$];
    int         errors;

    function new();
      errors = 0;
    endfunction

    function head_rule_t head_rule(input int h, input int avail, output int plen);
      plen = 0;
      case (rx_hist[h])
        CH_A, CH_B: begin
          plen = 4;
          return HEAD_FIXED;
        end
        CH_M, CH_P: begin
          plen = 2;
          return HEAD_FIXED;
        end
        CH_W, CH_G, CH_J, CH_N, CH_H, CH_I, CH_U: begin
          plen = 1;
          return HEAD_FIXED;
        end
        CH_K, CH_L: begin
          plen = 3;
          return HEAD_FIXED;
        end
        CH_V, CH_AT, CH_X, CH_Z: return HEAD_TO_CR;
        CH_S: begin
          if (avail < 2) return HEAD_WAIT;
          if (rx_hist[h+1][TX_BIT]) begin
            plen = 2;
            return HEAD_FIXED;
          end
          return HEAD_TO_CR;
        end
        CH_C: begin
          if (avail < 3) return HEAD_WAIT;
          plen = 3;
          if (rx_hist[h+1] == CH_ONE && rx_hist[h+2] == CH_T) plen = 4;
          if (rx_hist[h+1] == CH_ONE && rx_hist[h+2] == CH_X) plen = 5;
          return HEAD_FIXED;
        end
        default: return HEAD_DROP;
      endcase
    endfunction

    function void note_request(input logic [7:0] rx_byte);
      int         head;
      int         avail;
      int         plen;
      int         stop;
      int         count;
      head_rule_t rule;
      beat_t      beat;
      if (rx_hist.size() >= BUF_DEPTH) void'(rx_hist.pop_front());
      rx_hist.push_back(rx_byte);
      head  = 0;
      count = 0;
      while (1) begin
        avail = rx_hist.size() - head;
        if (avail == 0) break;
        rule = head_rule(head, avail, plen);
        if (rule == HEAD_WAIT) break;
        if (rule == HEAD_DROP) begin
          head++;
          continue;
        end
        if (rule == HEAD_TO_CR) begin
          stop = 0;
          while (stop < avail && rx_hist[head+stop] != CR_BYTE) stop++;
          if (stop >= avail) break;
        end else begin
          if (avail < plen + 2) break;
          stop = plen + 1;
          if (rx_hist[head+stop] != CR_BYTE) begin
            head++;
            continue;
          end
        end
        for (int i = 0; i < stop && count < MAX_BEATS; i++) begin
          beat.data = rx_hist[head+i];
          beat.last = (i + 1 == stop);
          frame_beats.push_back(beat);
          count++;
        end
        head += stop + 1;
      end
      repeat (head) void'(rx_hist.pop_front());
    endfunction

    function void check_result(input logic [7:0] data, input logic last);
      beat_t want;
      if (frame_beats.size() == 0) begin
        $error("frame_byte: expected none, actual %02h", data);
        errors++;
        return;
      end
      want = frame_beats.pop_front();
      if (want.data !== data) begin
        $error("frame_byte: expected %02h, actual %02h", want.data, data);
        errors++;
      end
      if (want.last !== last) begin
        $error("frame_last: expected %0b, actual %0b", want.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return frame_beats.size();
    endfunction
  endclass

  localparam int RANDOM_ITEMS = 110;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 800;
  localparam int CYCLE_LIMIT  = 3000000;

  typedef enum {PACE_FULL, PACE_HALF, PACE_LIGHT, PACE_BURSTY} pace_t;

  logic       clk;
  logic       rst      = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata  = 8'h00;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;

  frame_scoreboard sb;
  logic [7:0]      rx_plan[$];
  int              accepted  = 0;
  int              hold_at   = 0;
  bit              hold_done = 1'b0;
  int              cycles    = 0;

  response_frame_splitter_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CR_BYTE);
    return b;
  endfunction

  function automatic void fixed_kind(input int k, output logic [7:0] p, output int plen);
    case (k)
      0:  begin p = CH_A; plen = 4; end
      1:  begin p = CH_B; plen = 4; end
      2:  begin p = CH_M; plen = 2; end
      3:  begin p = CH_P; plen = 2; end
      4:  begin p = CH_W; plen = 1; end
      5:  begin p = CH_G; plen = 1; end
      6:  begin p = CH_J; plen = 1; end
      7:  begin p = CH_N; plen = 1; end
      8:  begin p = CH_H; plen = 1; end
      9:  begin p = CH_I; plen = 1; end
      10: begin p = CH_U; plen = 1; end
      11: begin p = CH_K; plen = 3; end
      default: begin p = CH_L; plen = 3; end
    endcase
  endfunction

  function automatic logic [7:0] text_prefix(input int k);
    case (k)
      0:       return CH_V;
      1:       return CH_AT;
      2:       return CH_X;
      default: return CH_Z;
    endcase
  endfunction

  // fixed frame; slip puts a non-cr byte where the cr belongs
  function automatic void add_fixed(input logic [7:0] p, input int plen, input bit slip);
    rx_plan.push_back(p);
    repeat (plen) rx_plan.push_back(8'($urandom_range(0, 255)));
    rx_plan.push_back(slip ? text_byte() : CR_BYTE);
  endfunction

  function automatic void add_text(input logic [7:0] p, input int n);
    rx_plan.push_back(p);
    repeat (n) rx_plan.push_back(text_byte());
    rx_plan.push_back(CR_BYTE);
  endfunction

  function automatic void add_c(input int variant);
    rx_plan.push_back(CH_C);
    case (variant)
      0: repeat (3) rx_plan.push_back(8'($urandom_range(0, 255)));
      1: begin
        rx_plan.push_back(CH_ONE);
        rx_plan.push_back(CH_T);
        repeat (2) rx_plan.push_back(8'($urandom_range(0, 255)));
      end
      default: begin
        rx_plan.push_back(CH_ONE);
        rx_plan.push_back(CH_X);
        repeat (3) rx_plan.push_back(8'($urandom_range(0, 255)));
      end
    endcase
    rx_plan.push_back(CR_BYTE);
  endfunction

  function automatic void build_directed();
    logic [7:0] p;
    int         plen;
    // extremes in the four-byte payload of an A frame
    rx_plan.push_back(CH_A);
    rx_plan.push_back(8'h00);
    rx_plan.push_back(8'hFF);
    rx_plan.push_back(8'h7F);
    rx_plan.push_back(8'h80);
    rx_plan.push_back(CR_BYTE);
    for (int k = 1; k < 13; k++) begin
      fixed_kind(k, p, plen);
      add_fixed(p, plen, 1'b0);
    end
    for (int k = 0; k < 4; k++) add_text(text_prefix(k), k);
    // s with tx mark, s with three random text bytes, s ended at once
    rx_plan.push_back(CH_S);
    rx_plan.push_back(8'h80);
    rx_plan.push_back(8'h01);
    rx_plan.push_back(CR_BYTE);
    add_text(CH_S, 3);
    add_text(CH_S, 0);
    for (int k = 0; k < 3; k++) add_c(k);
    // unknown heads
    rx_plan.push_back(8'h00);
    rx_plan.push_back(8'hFF);
    rx_plan.push_back(CR_BYTE);
    add_fixed(CH_W, 1, 1'b0);
    // framing slip, then a good frame
    add_fixed(CH_K, 3, 1'b1);
    add_fixed(CH_M, 2, 1'b0);
    // longest frame that fits, then overflow of a pending text frame
    add_text(CH_V, BUF_DEPTH - 2);
    rx_plan.push_back(CH_Z);
    repeat (BUF_DEPTH + 2) rx_plan.push_back(8'h2E);
    rx_plan.push_back(CR_BYTE);
  endfunction

  function automatic void add_random();
    logic [7:0] p;
    int         plen;
    int         r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      repeat ($urandom_range(1, 4)) rx_plan.push_back(8'($urandom_range(0, 255)));
    end else if (r < 18) begin
      fixed_kind($urandom_range(0, 12), p, plen);
      add_fixed(p, plen, 1'b1);
    end else if (r < 22) begin
      // cut short, no cr
      fixed_kind($urandom_range(0, 12), p, plen);
      rx_plan.push_back(p);
      repeat ($urandom_range(0, plen)) rx_plan.push_back(text_byte());
    end else if (r < 25) begin
      add_text(text_prefix($urandom_range(0, 3)), $urandom_range(30, BUF_DEPTH + 6));
    end else if (r < 45) begin
      fixed_kind($urandom_range(0, 12), p, plen);
      add_fixed(p, plen, 1'b0);
    end else if (r < 60) begin
      add_text(text_prefix($urandom_range(0, 3)), $urandom_range(0, 8));
    end else if (r < 66) begin
      rx_plan.push_back(CH_S);
      rx_plan.push_back(8'($urandom_range(128, 255)));
      rx_plan.push_back(8'($urandom_range(0, 255)));
      rx_plan.push_back(CR_BYTE);
    end else if (r < 72) begin
      rx_plan.push_back(CH_S);
      add_text(8'($urandom_range(0, 127)), $urandom_range(0, 5));
    end else if (r < 87) begin
      add_c($urandom_range(0, 2));
    end else begin
      rx_plan.push_back(8'($urandom_range(0, 255)));
      fixed_kind($urandom_range(0, 12), p, plen);
      add_fixed(p, plen, 1'b0);
    end
  endfunction

  task automatic send_rx(input logic [7:0] rx_byte);
    s_tvalid <= 1'b1;
    s_tdata  <= rx_byte;
    do @(posedge clk); while (!s_tready);
    sb.note_request(rx_byte);
    accepted++;
  endtask

  // result check
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("response_frame_splitter_top test failed");
      $finish;
    end
  end

  // receiver pacing, with one long hold-off
  initial begin : sink_pacing
    pace_t pace;
    int    phase_left;
    int    stall_left;
    pace       = PACE_FULL;
    phase_left = 0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!hold_done && hold_at > 0 && accepted >= hold_at) begin
        hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (phase_left == 0) begin
        pace       = pace_t'($urandom_range(0, 3));
        phase_left = $urandom_range(20, 120);
      end
      phase_left--;
      case (pace)
        PACE_FULL:  m_tready <= 1'b1;
        PACE_HALF:  m_tready <= 1'($urandom_range(0, 1));
        PACE_LIGHT: m_tready <= ($urandom_range(0, 7) != 0);
        default: begin
          if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
          end else if ($urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(3, 25);
            m_tready <= 1'b0;
          end else begin
            m_tready <= 1'b1;
          end
        end
      endcase
    end
  end

  initial begin : source
    int directed_n;
    int burst_left;
    int gap;
    sb = new();
    build_directed();
    directed_n = rx_plan.size();
    while (rx_plan.size() < directed_n + RANDOM_ITEMS) add_random();
    hold_at = directed_n + 40;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    burst_left = $urandom_range(1, 16);
    foreach (rx_plan[k]) begin
      send_rx(rx_plan[k]);
      burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        if ($urandom_range(0, 3) != 0) begin
          s_tvalid <= 1'b0;
          gap = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 20);
          repeat (gap) @(posedge clk);
        end
      end
    end
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("response_frame_splitter_top test passed");
    end else begin
      $display("response_frame_splitter_top test failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/rfs_pkg.sv
rtl/rfs_front.sv
rtl/rfs_scan.sv
rtl/response_frame_splitter_top.sv
dv/response_frame_splitter_top_tb.sv
